[rtl/multi_source_delay_pan_mixer_defines.svh]
// Assertion macros for the mixer. Each checks on the rising edge of clock.
`ifndef MULTI_SOURCE_DELAY_PAN_MIXER_DEFINES_SVH
`define MULTI_SOURCE_DELAY_PAN_MIXER_DEFINES_SVH

`ifndef SYNTHESIS

`define MSDPM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define MSDPM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define MSDPM_ASSERT(label, prop, msg)

`define MSDPM_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[rtl/msdpm_pkg.sv]
package msdpm_pkg;

   // Ring depth; the entry index wraps by masking, so it must be a power of two.
   localparam int DEPTH      = 16384;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int NSRC       = 5;
   localparam int SRC_W      = $clog2(NSRC);
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int DELAY_W    = 14;
   localparam int STORE_W    = 24;
   localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
   localparam int FRAC_SHIFT = 12;
   localparam int ROUND_BIAS = 2048;
   localparam int SCALED_W   = PROD_W - FRAC_SHIFT;
   localparam int SETUP_W    = 2 * DELAY_W + 2 * GAIN_W;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [STORE_W-1:0]  store_type;
   typedef logic [ADDR_W-1:0]          addr_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_r;
      logic [GAIN_W-1:0]  gain_l;
      logic [DELAY_W-1:0] delay_r;
      logic [DELAY_W-1:0] delay_l;
   } setup_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_FETCH,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic clearing;
      logic emitting;
   } ctrl_status_type;

endpackage

[rtl/msdpm_req_if.sv]
interface msdpm_req_if import msdpm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_a;
   sample_type sample_b;
   sample_type sample_c;
   sample_type sample_d;
   sample_type sample_e;

   modport source (
      output valid, sample_a, sample_b, sample_c, sample_d, sample_e,
      input  ready
   );

   modport sink (
      input  valid, sample_a, sample_b, sample_c, sample_d, sample_e,
      output ready
   );
endinterface

[rtl/msdpm_rsp_if.sv]
interface msdpm_rsp_if import msdpm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type left_sample;
   sample_type right_sample;

   modport source (
      output valid, left_sample, right_sample,
      input  ready
   );

   modport sink (
      input  valid, left_sample, right_sample,
      output ready
   );
endinterface

[rtl/msdpm_ring_ram.sv]
module msdpm_ring_ram #(
   parameter int DATA_W  = 24,
   parameter int ENTRIES = 16384,
   parameter int ADDR_W  = $clog2(ENTRIES)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

[rtl/msdpm_csr.sv]
module msdpm_csr import msdpm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output setup_type             setup [NSRC]
);

   setup_type        setup_ff [NSRC];
   logic [SRC_W-1:0] reg_index;
   logic             reg_valid;
   logic             write_en;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1 -: SRC_W];
   assign reg_valid  = (reg_index < SRC_W'(NSRC));
   assign write_en   = csr_psel && csr_penable && csr_pwrite && reg_valid;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSRC; i++) begin
            setup_ff[i] <= '0;
         end
      end else if (write_en) begin
         setup_ff[reg_index] <= setup_type'(csr_pwdata[SETUP_W-1:0]);
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_valid) begin
         csr_prdata = CSR_DATA_W'(setup_ff[reg_index]);
      end
   end

   assign setup = setup_ff;

endmodule

[rtl/msdpm_ctrl.sv]
module msdpm_ctrl import msdpm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  setup_type       setup [NSRC],
   msdpm_req_if.sink       req_chan,
   msdpm_rsp_if.source     rsp_chan,
   output ctrl_status_type status
);

   ctrl_state_type     state_ff, state_in;
   logic [SRC_W-1:0]   src_ff, src_in;
   addr_type           pos_ff, pos_in;
   addr_type           clr_ff, clr_in;
   sample_type         sample_ff [NSRC];
   sample_type         sample_in [NSRC];
   logic signed [PROD_W-1:0] prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;
   addr_type           waddr_l_ff, waddr_l_in, waddr_r_ff, waddr_r_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sample_type         rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;

   logic               we_l, we_r;
   addr_type           ram_waddr_l, ram_waddr_r, ram_raddr_l, ram_raddr_r;
   store_type          wdata_l, wdata_r, rdata_l, rdata_r;
   addr_type           idx_l, idx_r;
   logic               slot_free;
   logic               last_src;
   setup_type          cur_setup;

   function automatic addr_type wrap_index(addr_type pos, logic [DELAY_W-1:0] delay);
      logic [DELAY_W:0] sum;
      sum = {1'b0, delay} + {{(DELAY_W + 1 - ADDR_W){1'b0}}, pos};
      return sum[ADDR_W-1:0];
   endfunction

   function automatic store_type accumulate(store_type acc, logic signed [PROD_W-1:0] prod);
      logic signed [PROD_W-1:0]   biased;
      logic signed [SCALED_W-1:0] scaled;
      logic signed [STORE_W:0]    sum;
      biased = prod + PROD_W'(ROUND_BIAS);
      scaled = biased[PROD_W-1:FRAC_SHIFT];
      sum    = (STORE_W + 1)'(acc) + (STORE_W + 1)'(scaled);
      if (sum[STORE_W] != sum[STORE_W-1]) begin
         return {sum[STORE_W], {(STORE_W - 1){~sum[STORE_W]}}};
      end
      return sum[STORE_W-1:0];
   endfunction

   function automatic sample_type clamp(store_type v);
      if (v[STORE_W-1:SAMPLE_W-1] != {(STORE_W - SAMPLE_W + 1){v[STORE_W-1]}}) begin
         return {v[STORE_W-1], {(SAMPLE_W - 1){~v[STORE_W-1]}}};
      end
      return v[SAMPLE_W-1:0];
   endfunction

   msdpm_ring_ram #(
      .DATA_W  (STORE_W),
      .ENTRIES (DEPTH),
      .ADDR_W  (ADDR_W)
   ) u_left_ram (
      .clock (clock),
      .we    (we_l),
      .waddr (ram_waddr_l),
      .wdata (wdata_l),
      .raddr (ram_raddr_l),
      .rdata (rdata_l)
   );

   msdpm_ring_ram #(
      .DATA_W  (STORE_W),
      .ENTRIES (DEPTH),
      .ADDR_W  (ADDR_W)
   ) u_right_ram (
      .clock (clock),
      .we    (we_r),
      .waddr (ram_waddr_r),
      .wdata (wdata_r),
      .raddr (ram_raddr_r),
      .rdata (rdata_r)
   );

   assign cur_setup = setup[src_ff];
   assign idx_l     = wrap_index(pos_ff, cur_setup.delay_l);
   assign idx_r     = wrap_index(pos_ff, cur_setup.delay_r);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign last_src  = (src_ff == SRC_W'(NSRC - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = last_src ? ST_FETCH : ST_READ;
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      src_in       = src_ff;
      pos_in       = pos_ff;
      clr_in       = clr_ff;
      sample_in    = sample_ff;
      prod_l_in    = prod_l_ff;
      prod_r_in    = prod_r_ff;
      waddr_l_in   = waddr_l_ff;
      waddr_r_in   = waddr_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      we_l         = 1'b0;
      we_r         = 1'b0;
      ram_waddr_l  = waddr_l_ff;
      ram_waddr_r  = waddr_r_ff;
      wdata_l      = '0;
      wdata_r      = '0;
      ram_raddr_l  = pos_ff;
      ram_raddr_r  = pos_ff;
      req_chan.ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            we_l        = 1'b1;
            we_r        = 1'b1;
            ram_waddr_l = clr_ff;
            ram_waddr_r = clr_ff;
            clr_in      = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               sample_in[0] = req_chan.sample_a;
               sample_in[1] = req_chan.sample_b;
               sample_in[2] = req_chan.sample_c;
               sample_in[3] = req_chan.sample_d;
               sample_in[4] = req_chan.sample_e;
               src_in       = '0;
            end
         end
         ST_READ: begin
            ram_raddr_l = idx_l;
            ram_raddr_r = idx_r;
            waddr_l_in  = idx_l;
            waddr_r_in  = idx_r;
            prod_l_in   = PROD_W'(sample_ff[src_ff])
                          * PROD_W'($signed({1'b0, cur_setup.gain_l}));
            prod_r_in   = PROD_W'(sample_ff[src_ff])
                          * PROD_W'($signed({1'b0, cur_setup.gain_r}));
         end
         ST_UPDATE: begin
            we_l    = 1'b1;
            we_r    = 1'b1;
            wdata_l = accumulate(rdata_l, prod_l_ff);
            wdata_r = accumulate(rdata_r, prod_r_ff);
            if (!last_src) begin
               src_in = src_ff + 1'b1;
            end
         end
         ST_FETCH: begin
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = clamp(rdata_l);
               rsp_right_in = clamp(rdata_r);
               we_l         = 1'b1;
               we_r         = 1'b1;
               ram_waddr_l  = pos_ff;
               ram_waddr_r  = pos_ff;
               pos_in       = (pos_ff == ADDR_W'(DEPTH - 1)) ? '0 : pos_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         src_ff       <= '0;
         pos_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_ff       <= src_in;
         pos_ff       <= pos_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      prod_l_ff    <= prod_l_in;
      prod_r_ff    <= prod_r_in;
      waddr_l_ff   <= waddr_l_in;
      waddr_r_ff   <= waddr_r_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.left_sample  = rsp_left_ff;
   assign rsp_chan.right_sample = rsp_right_ff;

   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.emitting = (state_ff == ST_EMIT);

endmodule

[rtl/multi_source_delay_pan_mixer.sv]
// Five-source delay and pan mixer. Each request carries one sample per source;
// every sample is scaled by its source's left and right Q4.12 gains and added,
// with 24-bit saturation, into the left and right ring memories at the current
// position plus that source's delay. The two entries at the current position
// are then clamped to 16 bits, returned as one response, and cleared. A frame
// accepts the request, then reads, modifies and writes both rings (which work
// in parallel) for each source in turn, then fetches, returns and clears the
// output entries; these steps follow from the single read and single write port
// of each ring memory. The response waits in an output register, so the next
// request is taken while it is pending and only the final step of that frame
// holds until the response is collected. After reset both rings are cleared
// one entry per cycle across all 16384 entries; no request is accepted during
// the clear, while register writes are taken throughout.
`include "multi_source_delay_pan_mixer_defines.svh"

module multi_source_delay_pan_mixer import msdpm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   msdpm_req_if.sink             req_chan,
   msdpm_rsp_if.source           rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   setup_type       setup [NSRC];
   ctrl_status_type status;

   msdpm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .setup       (setup)
   );

   msdpm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .setup    (setup),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .status   (status)
   );

   `MSDPM_ASSERT_ALWAYS(a_reset_starts_clear, reset |=> status.clearing, "clear pass not started")
   `MSDPM_ASSERT(a_no_request_in_clear, status.clearing |-> !req_chan.ready, "request taken in clear")
   `MSDPM_ASSERT(a_one_frame_at_a_time, (req_chan.valid && req_chan.ready) |=> !req_chan.ready, "overlapping frames")
   `MSDPM_ASSERT(a_response_from_emit, $rose(rsp_chan.valid) |-> $past(status.emitting), "stray response")

endmodule
